/* design/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // field widths
   localparam int ADDR_W = 24;
   localparam int SIZE_W = 24;
   localparam int STAT_W = 2;

   // default table depth
   localparam int MAX_BLOCKS_DEF = 64;

   // header laid down in front of every appended block
   localparam int HEADER_BYTES = 24;

   // address space of the heap, in bits
   localparam int ADDR_BITS = 24;

   // request codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

   // reset value of the heap limit register
   localparam logic [ADDR_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

   // one block table entry
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] bytes;
      logic              free;
   } entry_type;

   // one result transaction
   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [STAT_W-1:0] status;
   } result_type;

endpackage

/* design/first_fit_block_allocator.sv */
// Flow: a zero size or null address goes from S_IDLE straight to S_DONE;
// otherwise the request walks the table in S_SCAN (skipped when the table is
// empty), then S_HIT or S_MISS, then S_DONE, and the response is registered.
// Throughput: one request at a time; the table walk reads one entry a cycle
// from the single read port.
// Reset: empty table, heap top zero, heap limit all ones; no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with a block table, append at the heap top and
// drop of the newest block on free; other freed blocks are marked free.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_heap_limit,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [SIZE_W-1:0] req_alloc_size,
   input  logic [ADDR_W-1:0] req_block_address,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [STAT_W-1:0] rsp_status
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [ADDR_W-1:0] limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   entry_type         rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;

   // heap limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_heap_limit;
      end
   end

   ffba_table #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   ffba_seq #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_alloc_size    (req_alloc_size),
      .req_block_address (req_block_address),
      .heap_limit        (limit_ff),
      .rd_en             (rd_en),
      .rd_idx            (rd_idx),
      .rd_data           (rd_data),
      .wr_en             (wr_en),
      .wr_idx            (wr_idx),
      .wr_data           (wr_data),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res)
   );

   // response output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_ff.result_address;
   assign rsp_status         = rsp_ff.status;

endmodule

/* design/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_data
);

   entry_type entry_mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_data;
      end
   end

   // read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ffba_seq.sv */
// ----------------------------------------------------------------------------
// ffba_seq
// Sequencer: walks the block table one entry per cycle through a shared
// compare unit, then grants, appends, marks free or drops a block.
// ----------------------------------------------------------------------------
module ffba_seq
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   // request transaction
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [SIZE_W-1:0] req_alloc_size,
   input  logic [ADDR_W-1:0] req_block_address,
   // heap limit register
   input  logic [ADDR_W-1:0] heap_limit,
   // table ports
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_idx,
   input  entry_type         rd_data,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_idx,
   output entry_type         wr_data,
   // finished result
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_HIT  = 3'd2;
   localparam logic [2:0] S_MISS = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam int               TOP_W    = ADDR_W + 2;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);
   localparam logic [TOP_W-1:0] HDR_WIDE = TOP_W'(HEADER_BYTES);
   localparam logic [TOP_W-1:0] SPACE_MAX = TOP_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [2:0]        state_ff, state_in;
   logic              func_ff, func_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   result_type        res_ff, res_in;

   logic              req_fire;
   logic              hit_now;
   logic              last_cmp;
   logic [TOP_W-1:0]  new_top;
   logic [ADDR_W-1:0] new_start;
   logic              no_space;
   logic [ADDR_W:0]   blk_end;
   logic              drop_newest;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // shared compare unit: fit test for allocate, address match for free
   always_comb begin
      if (func_ff == FUNC_ALLOC) begin
         hit_now = cmp_vld_ff && rd_data.free && (rd_data.bytes >= size_ff);
      end else begin
         hit_now = cmp_vld_ff && (rd_data.start == addr_ff);
      end
   end

   assign last_cmp = cmp_vld_ff && (cmp_idx_ff == (cnt_ff - CNT_ONE));

   // append arithmetic
   assign new_top   = {2'b00, top_ff} + HDR_WIDE + {2'b00, size_ff};
   assign new_start = top_ff + ADDR_W'(HEADER_BYTES);
   assign no_space  = (cnt_ff >= CNT_MAX) || (new_top > {2'b00, heap_limit})
                      || (new_top > SPACE_MAX);

   // newest block test for free
   assign blk_end     = {1'b0, rd_data.start} + {1'b0, rd_data.bytes};
   assign drop_newest = (cmp_idx_ff == (cnt_ff - CNT_ONE)) && (blk_end == {1'b0, top_ff});

   // table read issue
   assign rd_en  = (state_ff == S_SCAN) && !hit_now && (iss_ff < cnt_ff);
   assign rd_idx = iss_ff[IDX_W-1:0];

   // sequencer
   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      size_in    = size_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      top_in     = top_ff;
      iss_in     = iss_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      res_in     = res_ff;
      wr_en      = 1'b0;
      wr_idx     = cmp_idx_ff[IDX_W-1:0];
      wr_data    = rd_data;
      case (state_ff)
         S_IDLE: begin
            iss_in     = '0;
            cmp_vld_in = 1'b0;
            if (req_fire) begin
               func_in = req_func;
               size_in = req_alloc_size;
               addr_in = req_block_address;
               if ((req_func == FUNC_ALLOC && req_alloc_size == '0) ||
                   (req_func == FUNC_FREE && req_block_address == '0)) begin
                  res_in   = '{result_address: '0, status: ST_NULL};
                  state_in = S_DONE;
               end else if (cnt_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            iss_in     = iss_ff + CNT_W'(rd_en);
            cmp_vld_in = rd_en;
            cmp_idx_in = iss_ff;
            if (hit_now) begin
               cmp_vld_in = 1'b0;
               cmp_idx_in = cmp_idx_ff;
               state_in   = S_HIT;
            end else if (last_cmp) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            if (func_ff == FUNC_ALLOC) begin
               // grant the first fitting free block
               wr_en        = 1'b1;
               wr_data.free = 1'b0;
               res_in       = '{result_address: rd_data.start, status: ST_OK};
            end else begin
               if (drop_newest) begin
                  top_in = rd_data.start - ADDR_W'(HEADER_BYTES);
                  cnt_in = cmp_idx_ff;
               end else begin
                  wr_en        = 1'b1;
                  wr_data.free = 1'b1;
               end
               res_in = '{result_address: '0, status: ST_OK};
            end
            state_in = S_DONE;
         end
         S_MISS: begin
            if (func_ff == FUNC_FREE) begin
               res_in = '{result_address: '0, status: ST_UNKNOWN};
            end else if (no_space) begin
               res_in = '{result_address: '0, status: ST_NOSPACE};
            end else begin
               // append a new block at the heap top
               wr_en   = 1'b1;
               wr_idx  = cnt_ff[IDX_W-1:0];
               wr_data = '{start: new_start, bytes: size_ff, free: 1'b0};
               cnt_in  = cnt_ff + CNT_ONE;
               top_in  = new_top[ADDR_W-1:0];
               res_in  = '{result_address: new_start, status: ST_OK};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         top_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         top_ff     <= top_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("block count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a request transaction");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HIT |-> cmp_idx_ff < cnt_ff)
      else $error("hit entry outside the live table");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_HIT || state_ff == S_MISS))
      else $error("table write outside grant or append");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator. A cycle-free model of
// the block table and heap top predicts every response; directed tests cover
// rejects, reuse, the heap limit and a full table, then random alloc and free
// traffic runs under several heap limits with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
   import ffba_pkg::*;

   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = MAX_BLOCKS_DEF + 8;
   localparam longint unsigned SPACE_TOP = (64'd1 << ADDR_BITS) - 1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ADDR_W-1:0] csr_heap_limit = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_func = FUNC_ALLOC;
   logic [SIZE_W-1:0] req_alloc_size = '0;
   logic [ADDR_W-1:0] req_block_address = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_result_address;
   logic [STAT_W-1:0] rsp_status;

   // shadow of the block table and heap
   logic [ADDR_W-1:0] blk_start [MAX_BLOCKS_DEF];
   logic [SIZE_W-1:0] blk_bytes [MAX_BLOCKS_DEF];
   bit                blk_free  [MAX_BLOCKS_DEF];
   int unsigned       blk_count = 0;
   longint unsigned   heap_top_now = 0;
   logic [ADDR_W-1:0] heap_limit_now = LIMIT_RESET;

   result_type due_outcomes [$];

   // traffic shaping
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int rsp_hold_cycles = 0;

   // bookkeeping
   int errors = 0;
   int items_sent = 0;
   int limit_writes = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   first_fit_block_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_heap_limit     (csr_heap_limit),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_alloc_size     (req_alloc_size),
      .req_block_address  (req_block_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status)
   );

   always #6 clock = ~clock;

   // allocate: first free block that fits, else append at the heap top
   function automatic result_type heap_alloc(input logic [SIZE_W-1:0] size);
      result_type      res;
      longint unsigned grown;
      res.result_address = '0;
      res.status = ST_OK;
      if (size == 0) begin
         res.status = ST_NULL;
         return res;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_bytes[i] >= size) begin
            blk_free[i] = 1'b0;
            res.result_address = blk_start[i];
            return res;
         end
      end
      grown = heap_top_now + HEADER_BYTES + size;
      if (blk_count >= MAX_BLOCKS_DEF || grown > heap_limit_now || grown > SPACE_TOP) begin
         res.status = ST_NOSPACE;
         return res;
      end
      blk_start[blk_count] = ADDR_W'(heap_top_now + HEADER_BYTES);
      blk_bytes[blk_count] = size;
      blk_free[blk_count] = 1'b0;
      res.result_address = blk_start[blk_count];
      blk_count++;
      heap_top_now = grown;
      return res;
   endfunction

   // free: drop the newest block, otherwise just mark it free
   function automatic result_type heap_release(input logic [ADDR_W-1:0] addr);
      result_type res;
      int         hit;
      res.result_address = '0;
      res.status = ST_OK;
      hit = -1;
      if (addr == 0) begin
         res.status = ST_NULL;
         return res;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (hit < 0 && blk_start[i] == addr) hit = i;
      end
      if (hit < 0) begin
         res.status = ST_UNKNOWN;
         return res;
      end
      if (hit + 1 == blk_count && blk_start[hit] + blk_bytes[hit] == heap_top_now) begin
         heap_top_now = 64'(blk_start[hit]) - 64'(HEADER_BYTES);
         blk_count = hit;
      end else begin
         blk_free[hit] = 1'b1;
      end
      return res;
   endfunction

   // one request transaction, predicted on acceptance
   task automatic send_request(input logic func, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      int         gap;
      result_type outcome;
      gap = req_gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_alloc_size <= size;
      req_block_address <= addr;
      do @(posedge clock); while (!req_ready);
      outcome = (func == FUNC_ALLOC) ? heap_alloc(size) : heap_release(addr);
      status_seen[outcome.status]++;
      due_outcomes.push_back(outcome);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic alloc_bytes(input logic [SIZE_W-1:0] size);
      send_request(FUNC_ALLOC, size, ADDR_W'($urandom));
   endtask

   task automatic free_block(input logic [ADDR_W-1:0] addr);
      send_request(FUNC_FREE, SIZE_W'($urandom), addr);
   endtask

   // stop offering requests until every response is back, then let it settle
   task automatic wait_drained;
      int spin;
      spin = 0;
      req_valid <= 1'b0;
      while (due_outcomes.size() != 0 && spin < DRAIN_LIMIT) begin
         @(negedge clock);
         spin++;
      end
      if (due_outcomes.size() != 0) begin
         errors++;
         $display("drain stuck with %0d responses outstanding", due_outcomes.size());
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // heap limit write, only while the block is idle
   task automatic write_heap_limit(input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_heap_limit <= value;
      do @(posedge clock); while (!csr_ready);
      heap_limit_now = value;
      limit_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // rejects, first-fit reuse, double free and dropping the newest block
   task automatic test_rejects_and_reuse;
      logic [ADDR_W-1:0] newest;
      send_request(FUNC_ALLOC, '0, '1);
      send_request(FUNC_FREE, '1, '0);
      free_block(24'hFF_FFFF);
      free_block(24'h12_3456);
      alloc_bytes(1);
      alloc_bytes(100);
      alloc_bytes(24'hFF_FFFF);
      alloc_bytes(16);
      free_block(blk_start[0]);
      free_block(blk_start[0]);
      alloc_bytes(1);
      free_block(blk_start[1]);
      alloc_bytes(50);
      newest = blk_start[blk_count - 1];
      free_block(newest);
      free_block(newest);
      alloc_bytes(200);
      free_block(blk_start[1]);
      free_block(blk_start[blk_count - 1]);
      alloc_bytes(24'h80_0001);
      free_block(blk_start[blk_count - 1]);
      wait_drained();
   endtask

   // growth stops exactly at the heap limit
   task automatic test_heap_limit;
      write_heap_limit('0);
      alloc_bytes(500);
      alloc_bytes(24'hFF_FFFF);
      wait_drained();
      write_heap_limit(ADDR_W'(heap_top_now + HEADER_BYTES + 400));
      alloc_bytes(400);
      alloc_bytes(500);
      free_block(blk_start[blk_count - 1]);
      wait_drained();
      write_heap_limit(LIMIT_RESET);
   endtask

   // fill every table entry, overflow it, then unwind from the top
   task automatic test_table_full;
      int guard;
      guard = 0;
      while (blk_count < MAX_BLOCKS_DEF && guard < 4 * MAX_BLOCKS_DEF) begin
         alloc_bytes(8);
         guard++;
      end
      alloc_bytes(24'hFF_FFFF);
      alloc_bytes(4096);
      free_block(blk_start[MAX_BLOCKS_DEF / 3]);
      alloc_bytes(8);
      guard = 0;
      while (blk_count > 0 && guard < 4 * MAX_BLOCKS_DEF) begin
         free_block(blk_start[blk_count - 1]);
         guard++;
      end
      wait_drained();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure;
      req_gaps = 1'b0;
      rsp_hold_cycles = 300;
      for (int n = 0; n < 12; n++) alloc_bytes(SIZE_W'($urandom_range(1, 64)));
      for (int n = 0; n < 6; n++) free_block(blk_start[$urandom_range(0, blk_count - 1)]);
      req_gaps = 1'b1;
      wait_drained();
   endtask

   // one random request, mostly well-formed alloc and free traffic
   task automatic random_request;
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         case ($urandom_range(0, 9))
            0:       alloc_bytes(SIZE_W'($urandom));
            1, 2:    alloc_bytes(SIZE_W'($urandom_range(1, 4096)));
            default: alloc_bytes(SIZE_W'($urandom_range(1, 64)));
         endcase
      end else if (pick < 88 && blk_count > 0) begin
         idx = ($urandom_range(0, 2) == 0) ? blk_count - 1 : $urandom_range(0, blk_count - 1);
         free_block(blk_start[idx]);
      end else begin
         case ($urandom_range(0, 3))
            0:       send_request(FUNC_ALLOC, '0, ADDR_W'($urandom));
            1:       send_request(FUNC_FREE, SIZE_W'($urandom), '0);
            2:       free_block(ADDR_W'(heap_top_now + HEADER_BYTES));
            default: free_block(ADDR_W'($urandom));
         endcase
      end
   endtask

   // random traffic under several heap limits
   task automatic test_random_traffic;
      logic [ADDR_W-1:0] limits [4];
      limits = '{LIMIT_RESET, 24'd3000, ADDR_W'($urandom_range(500, 20000)), 24'd1024};
      foreach (limits[p]) begin
         write_heap_limit(limits[p]);
         for (int n = 0; n < 160; n++) begin
            if (n % 40 == 0) begin
               req_gaps = $urandom_range(0, 3) != 0;
               rsp_gaps = $urandom_range(0, 3) != 0;
            end
            random_request();
         end
         wait_drained();
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // response side: random stall per transaction plus the requested hold-off
   initial begin : drive_rsp_ready
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = (rsp_gaps ? $urandom_range(0, 9) : 0) + rsp_hold_cycles;
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_outcomes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response at %0t: addr %h status %0d",
                        $realtime, rsp_result_address, rsp_status);
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_result_address !== want.result_address || rsp_status !== want.status) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("mismatch at %0t: expected addr %h status %0d, got addr %h status %0d",
                           $realtime, want.result_address, want.status,
                           rsp_result_address, rsp_status);
            end
         end
      end
   end

   // overall time limit
   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_rejects_and_reuse();
      test_heap_limit();
      test_table_full();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (due_outcomes.size() != 0) errors++;
      $display("covered %0d requests and %0d heap limit writes", items_sent, limit_writes);
      $display("responses: ok %0d, rejected %0d, no space %0d, unknown address %0d",
               status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_NOSPACE],
               status_seen[ST_UNKNOWN]);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
